>>> hdl/ssl_pkg.sv
// Package for the servo slew limiter: action and register index codes,
// constants, and the angle saturate and shared clamp functions. No dependencies.
`timescale 1ns / 1ps

package ssl_pkg;

  typedef enum logic [1:0] {
    ACT_TICK      = 2'd0,
    ACT_RAMP_SET  = 2'd1,
    ACT_JUMP_SET  = 2'd2,
    ACT_STOP      = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    REG_STEP_INTERVAL = 3'd0,
    REG_STEP_SIZE     = 3'd1,
    REG_AUTO_DETACH   = 3'd2,
    REG_DETACH_DELAY  = 3'd3,
    REG_LOW_LIMIT     = 3'd4,
    REG_HIGH_LIMIT    = 3'd5
  } reg_index_t;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CNT_W       = 16;
  localparam int unsigned TENTHS_W    = 11;
  localparam int unsigned STEP_W      = 11;
  localparam int unsigned DEG_W       = 8;
  localparam int unsigned CMP_W       = 12;

  localparam logic [DEG_W-1:0]    DEG_FULL      = 8'd180;
  localparam logic [CMP_W-1:0]    CMP_BASE      = 12'd500;
  // Compare span 2000/180 = 100/9, done as a multiply by 100 * round(2^16 / 9).
  localparam logic [19:0]         CMP_SCALE     = 20'd728200;
  // Multiply by 3277 and shift by 15 gives an exact floor(x / 10) for 11-bit x.
  localparam logic [11:0]         DIV10_RECIP   = 12'd3277;
  localparam logic [TENTHS_W-1:0] RST_TENTHS    = 11'd900;
  localparam logic [DEG_W-1:0]    RST_DEG       = 8'd90;
  localparam logic [CMP_W-1:0]    RST_CMP       = 12'd1500;

  typedef struct packed {
    logic [CNT_W-1:0]  step_interval;
    logic [STEP_W-1:0] step_size;
    logic              auto_detach;
    logic [CNT_W-1:0]  detach_delay;
    logic [DEG_W-1:0]  low_limit;
    logic [DEG_W-1:0]  high_limit;
  } cfg_t;

  // Result of the state update stage, handed to the compare stage.
  typedef struct packed {
    logic             valid;
    logic             cmp_update;
    logic [DEG_W-1:0] cmp_deg;
    logic             pwm_on;
    logic [DEG_W-1:0] present;
    logic [DEG_W-1:0] goal;
    logic             moving;
  } mid_t;

  function automatic logic [DEG_W-1:0] sat_deg(input logic [DEG_W-1:0] v);
    return (v > DEG_FULL) ? DEG_FULL : v;
  endfunction

  // The low test wins when the limits cross.
  function automatic logic [DEG_W-1:0] clamp_angle(input logic [DEG_W-1:0] a,
                                                   input logic [DEG_W-1:0] lo_raw,
                                                   input logic [DEG_W-1:0] hi_raw);
    logic [DEG_W-1:0] lo;
    logic [DEG_W-1:0] hi;
    lo = sat_deg(lo_raw);
    hi = sat_deg(hi_raw);
    if (a < lo) begin
      return lo;
    end else if (a > hi) begin
      return hi;
    end
    return a;
  endfunction

endpackage

>>> hdl/ssl_core.sv
// State update stage of the servo slew limiter: angle, target, elapsed counters
// and PWM enable. Depends on ssl_pkg.
`timescale 1ns / 1ps

module ssl_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        item_valid,
  input  ssl_pkg::action_t            item_action,
  input  logic [ssl_pkg::DEG_W-1:0]   item_angle,
  input  ssl_pkg::cfg_t               cfg,
  output ssl_pkg::mid_t               mid
);

  logic [ssl_pkg::TENTHS_W-1:0] tenths_r, tenths_nxt;
  logic [ssl_pkg::DEG_W-1:0]    present_r, present_nxt;
  logic [ssl_pkg::DEG_W-1:0]    target_r, target_nxt;
  logic [ssl_pkg::CNT_W-1:0]    since_step_r, since_step_nxt;
  logic [ssl_pkg::CNT_W-1:0]    since_move_r, since_move_nxt;
  logic                         pwm_r, pwm_nxt;
  ssl_pkg::mid_t                mid_r, mid_nxt;

  logic [ssl_pkg::CNT_W-1:0]    interval;
  logic [ssl_pkg::STEP_W-1:0]   stepsz;
  logic [ssl_pkg::CNT_W-1:0]    ss_inc, sm_inc;
  logic [ssl_pkg::TENTHS_W-1:0] goal_tenths;
  logic [ssl_pkg::TENTHS_W:0]   up_sum;
  logic [ssl_pkg::TENTHS_W-1:0] down_diff;
  logic [ssl_pkg::TENTHS_W-1:0] stepped;
  logic [22:0]                  div_prod;
  logic [ssl_pkg::DEG_W-1:0]    stepped_deg;
  logic [ssl_pkg::DEG_W-1:0]    req_clamped;
  logic                         do_step;

  function automatic logic [22:0] tenths_w_ext(input logic [ssl_pkg::TENTHS_W-1:0] v);
    return {12'd0, v};
  endfunction

  always_comb begin
    interval = (cfg.step_interval == '0) ? ssl_pkg::CNT_W'(1) : cfg.step_interval;
    stepsz   = (cfg.step_size == '0) ? ssl_pkg::STEP_W'(1) : cfg.step_size;
    ss_inc   = (since_step_r == '1) ? since_step_r : since_step_r + 1'b1;
    sm_inc   = (since_move_r == '1) ? since_move_r : since_move_r + 1'b1;

    goal_tenths = {target_r, 3'b000} + {2'b00, target_r, 1'b0};
    up_sum      = {1'b0, tenths_r} + {1'b0, stepsz};
    down_diff   = tenths_r - goal_tenths;
    if (tenths_r < goal_tenths) begin
      stepped = (up_sum > {1'b0, goal_tenths}) ? goal_tenths
                                               : up_sum[ssl_pkg::TENTHS_W-1:0];
    end else begin
      stepped = (down_diff > stepsz) ? tenths_r - stepsz : goal_tenths;
    end
    div_prod    = tenths_w_ext(stepped) * {11'd0, ssl_pkg::DIV10_RECIP};
    stepped_deg = div_prod[22:15];

    req_clamped = ssl_pkg::clamp_angle(item_angle, cfg.low_limit, cfg.high_limit);
    do_step     = (present_r != target_r) && (ss_inc >= interval);
  end

  always_comb begin
    tenths_nxt     = tenths_r;
    present_nxt    = present_r;
    target_nxt     = target_r;
    since_step_nxt = since_step_r;
    since_move_nxt = since_move_r;
    pwm_nxt        = pwm_r;
    mid_nxt        = '0;
    mid_nxt.cmp_deg = present_r;

    if (item_valid) begin
      unique case (item_action)
        ssl_pkg::ACT_TICK: begin
          since_step_nxt = ss_inc;
          since_move_nxt = sm_inc;
          if (present_r != target_r) begin
            if (do_step) begin
              since_step_nxt     = '0;
              since_move_nxt     = '0;
              pwm_nxt            = 1'b1;
              tenths_nxt         = stepped;
              present_nxt        = stepped_deg;
              mid_nxt.cmp_update = 1'b1;
              mid_nxt.cmp_deg    = stepped_deg;
            end
          end else if (cfg.auto_detach && pwm_r && (sm_inc >= cfg.detach_delay)) begin
            pwm_nxt = 1'b0;
          end
        end
        ssl_pkg::ACT_RAMP_SET: begin
          target_nxt     = req_clamped;
          since_move_nxt = '0;
          pwm_nxt        = 1'b1;
        end
        ssl_pkg::ACT_JUMP_SET: begin
          target_nxt         = req_clamped;
          since_move_nxt     = '0;
          pwm_nxt            = 1'b1;
          tenths_nxt         = {req_clamped, 3'b000} + {2'b00, req_clamped, 1'b0};
          present_nxt        = req_clamped;
          mid_nxt.cmp_update = 1'b1;
          mid_nxt.cmp_deg    = req_clamped;
        end
        ssl_pkg::ACT_STOP: begin
          pwm_nxt = 1'b0;
        end
        default: begin
          pwm_nxt = pwm_r;
        end
      endcase
    end

    mid_nxt.valid   = item_valid;
    mid_nxt.pwm_on  = pwm_nxt;
    mid_nxt.present = present_nxt;
    mid_nxt.goal    = target_nxt;
    mid_nxt.moving  = (present_nxt != target_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tenths_r     <= ssl_pkg::RST_TENTHS;
      present_r    <= ssl_pkg::RST_DEG;
      target_r     <= ssl_pkg::RST_DEG;
      since_step_r <= '0;
      since_move_r <= '0;
      pwm_r        <= 1'b1;
      mid_r        <= '0;
    end else if (en) begin
      tenths_r     <= tenths_nxt;
      present_r    <= present_nxt;
      target_r     <= target_nxt;
      since_step_r <= since_step_nxt;
      since_move_r <= since_move_nxt;
      pwm_r        <= pwm_nxt;
      mid_r        <= mid_nxt;
    end
  end

  assign mid = mid_r;

endmodule

>>> hdl/ssl_cmp.sv
// Compare stage of the servo slew limiter: holds the PWM compare value and the
// result register. Depends on ssl_pkg.
`timescale 1ns / 1ps

module ssl_cmp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  ssl_pkg::mid_t              mid,
  input  ssl_pkg::cfg_t              cfg,
  output logic                       out_valid,
  output logic [ssl_pkg::CMP_W-1:0]  out_pulse_compare,
  output logic                       out_output_enabled,
  output logic [ssl_pkg::DEG_W-1:0]  out_present_angle,
  output logic [ssl_pkg::DEG_W-1:0]  out_goal_angle,
  output logic                       out_in_motion
);

  logic [ssl_pkg::CMP_W-1:0] compare_r, compare_nxt;
  logic                      valid_r;
  logic                      pwm_r;
  logic [ssl_pkg::DEG_W-1:0] present_r;
  logic [ssl_pkg::DEG_W-1:0] goal_r;
  logic                      moving_r;

  logic [ssl_pkg::DEG_W-1:0] a;
  logic [27:0]               span_prod;

  always_comb begin
    a           = ssl_pkg::clamp_angle(mid.cmp_deg, cfg.low_limit, cfg.high_limit);
    span_prod   = {20'd0, a} * {8'd0, ssl_pkg::CMP_SCALE};
    compare_nxt = compare_r;
    if (mid.valid && mid.cmp_update) begin
      compare_nxt = ssl_pkg::CMP_BASE + span_prod[27:16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      compare_r <= ssl_pkg::RST_CMP;
      valid_r   <= 1'b0;
    end else if (en) begin
      compare_r <= compare_nxt;
      valid_r   <= mid.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pwm_r     <= mid.pwm_on;
      present_r <= mid.present;
      goal_r    <= mid.goal;
      moving_r  <= mid.moving;
    end
  end

  assign out_valid          = valid_r;
  assign out_pulse_compare  = compare_r;
  assign out_output_enabled = pwm_r;
  assign out_present_angle  = present_r;
  assign out_goal_angle     = goal_r;
  assign out_in_motion      = moving_r;

endmodule

>>> hdl/servo_slew_limiter_auto_detach.sv
// Top level of the servo slew limiter with auto detach: input register,
// configuration registers and the two processing stages. Depends on ssl_pkg,
// ssl_core and ssl_cmp.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake             Payload
//  in_       input      in_valid / in_stall   in_action, in_angle
//  out_      output     out_valid / out_stall pulse_compare, output_enabled,
//                                             present_angle, goal_angle, in_motion
//  cfg_      input      cfg_we                cfg_index, cfg_data
//
//  One transaction per cycle is sustained while the result channel does not
//  stall. The pipeline is the input register, the state update stage and
//  the compare stage with the result register. A stall on the result
//  channel freezes all three stages together and is passed back to in_stall
//  while the input register holds a transaction. Reset is synchronous and
//  active low; it returns the valid flags, servo state, compare value and
//  configuration to their defaults, but not the other payload registers.

module servo_slew_limiter_auto_detach (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_action,
  input  logic [ssl_pkg::DEG_W-1:0]        in_angle,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [ssl_pkg::CMP_W-1:0]        out_pulse_compare,
  output logic                             out_output_enabled,
  output logic [ssl_pkg::DEG_W-1:0]        out_present_angle,
  output logic [ssl_pkg::DEG_W-1:0]        out_goal_angle,
  output logic                             out_in_motion,
  input  logic                             cfg_we,
  input  logic [ssl_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ssl_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // The whole pipeline moves when the result register is empty or being taken.
  logic en;

  logic                      in_valid_r;
  ssl_pkg::action_t          in_action_r;
  logic [ssl_pkg::DEG_W-1:0] in_angle_r;
  logic                      in_take;

  ssl_pkg::cfg_t cfg_r;
  ssl_pkg::mid_t mid;

  assign en       = !out_valid || !out_stall;
  assign in_stall = in_valid_r && !en;
  assign in_take  = in_valid && !in_stall;

  // Input register. It loads a new transaction whenever it is empty or its
  // current content moves on to the state update stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (en || !in_valid_r) begin
      in_valid_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_action_r <= ssl_pkg::action_t'(in_action);
      in_angle_r  <= in_angle;
    end
  end

  // Configuration registers. Writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_interval <= 16'd3;
      cfg_r.step_size     <= 11'd20;
      cfg_r.auto_detach   <= 1'b1;
      cfg_r.detach_delay  <= 16'd500;
      cfg_r.low_limit     <= 8'd0;
      cfg_r.high_limit    <= ssl_pkg::DEG_FULL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ssl_pkg::REG_STEP_INTERVAL: cfg_r.step_interval <= cfg_data;
        ssl_pkg::REG_STEP_SIZE:     cfg_r.step_size     <= cfg_data[ssl_pkg::STEP_W-1:0];
        ssl_pkg::REG_AUTO_DETACH:   cfg_r.auto_detach   <= cfg_data[0];
        ssl_pkg::REG_DETACH_DELAY:  cfg_r.detach_delay  <= cfg_data;
        ssl_pkg::REG_LOW_LIMIT:     cfg_r.low_limit     <= cfg_data[ssl_pkg::DEG_W-1:0];
        ssl_pkg::REG_HIGH_LIMIT:    cfg_r.high_limit    <= cfg_data[ssl_pkg::DEG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // State update: slewing, counters and PWM enable. The compare value is
  // recomputed one stage later from the angle that this stage settles on.
  ssl_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .item_valid  (in_valid_r),
    .item_action (in_action_r),
    .item_angle  (in_angle_r),
    .cfg         (cfg_r),
    .mid         (mid)
  );

  ssl_cmp u_cmp (
    .clk                (clk),
    .rst_n              (rst_n),
    .en                 (en),
    .mid                (mid),
    .cfg                (cfg_r),
    .out_valid          (out_valid),
    .out_pulse_compare  (out_pulse_compare),
    .out_output_enabled (out_output_enabled),
    .out_present_angle  (out_present_angle),
    .out_goal_angle     (out_goal_angle),
    .out_in_motion      (out_in_motion)
  );

endmodule

>>> tb/servo_status_check.sv
// Status checker for the servo slew limiter: predicts each result from the input
// and configuration transactions and compares it with the block's output.
// Depends on ssl_pkg for the action and register index codes and the port widths.
`timescale 1ns / 1ps

module servo_status_check (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [1:0]                      in_action,
  input  logic [ssl_pkg::DEG_W-1:0]       in_angle,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [ssl_pkg::CMP_W-1:0]       out_pulse_compare,
  input  logic                            out_output_enabled,
  input  logic [ssl_pkg::DEG_W-1:0]       out_present_angle,
  input  logic [ssl_pkg::DEG_W-1:0]       out_goal_angle,
  input  logic                            out_in_motion,
  input  logic                            cfg_we,
  input  logic [ssl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ssl_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              mismatches,
  output int                              outstanding
);

  localparam int unsigned PULSE_MIN   = 500;
  localparam int unsigned PULSE_SPAN  = 2000;
  localparam int unsigned FULL_SWING  = 180;
  localparam int unsigned TENTHS      = 10;
  localparam logic [15:0] COUNT_TOP   = 16'hFFFF;
  localparam int          REPORT_MAX  = 10;

  typedef struct packed {
    logic [ssl_pkg::CMP_W-1:0] pulse;
    logic                      enabled;
    logic [ssl_pkg::DEG_W-1:0] present;
    logic [ssl_pkg::DEG_W-1:0] goal;
    logic                      moving;
  } servo_status_t;

  // Configuration copy.
  logic [15:0] pace_ms;
  logic [10:0] step_tenths;
  logic        detach_en;
  logic [15:0] detach_ms;
  logic [7:0]  lo_lim;
  logic [7:0]  hi_lim;

  // Servo state copy.
  logic [10:0] tenths;
  logic [7:0]  goal_deg;
  logic [15:0] step_age;
  logic [15:0] idle_age;
  logic        drive_on;
  logic [11:0] pulse_reg;

  servo_status_t pending_status[$];

  // Limits saturate at full swing; when they cross, the low test is checked first.
  function automatic logic [7:0] limit_angle(input logic [7:0] a);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = (lo_lim > FULL_SWING) ? 8'(FULL_SWING) : lo_lim;
    hi = (hi_lim > FULL_SWING) ? 8'(FULL_SWING) : hi_lim;
    if (a < lo) return lo;
    if (a > hi) return hi;
    return a;
  endfunction

  function automatic logic [11:0] pulse_for(input logic [7:0] deg);
    int unsigned a;
    a = limit_angle(deg);
    return 12'(PULSE_MIN + (a * PULSE_SPAN) / FULL_SWING);
  endfunction

  task automatic advance_servo(input ssl_pkg::action_t act, input logic [7:0] req,
                               output servo_status_t st);
    int unsigned pace;
    int unsigned stride;
    int unsigned pos;
    int unsigned aim;
    logic [7:0]  whole;
    pace   = (pace_ms == 0) ? 1 : pace_ms;
    stride = (step_tenths == 0) ? 1 : step_tenths;
    case (act)
      ssl_pkg::ACT_TICK: begin
        step_age = (step_age == COUNT_TOP) ? step_age : step_age + 16'd1;
        idle_age = (idle_age == COUNT_TOP) ? idle_age : idle_age + 16'd1;
        whole = 8'(tenths / TENTHS);
        if (whole != goal_deg) begin
          if (step_age >= pace) begin
            aim = goal_deg * TENTHS;
            pos = tenths;
            step_age = '0;
            idle_age = '0;
            drive_on = 1'b1;
            // Step toward the goal and never past it.
            if (pos < aim) begin
              pos = (pos + stride > aim) ? aim : pos + stride;
            end else begin
              pos = (pos - aim > stride) ? pos - stride : aim;
            end
            tenths = 11'(pos);
            pulse_reg = pulse_for(8'(pos / TENTHS));
          end
        end else if (detach_en && drive_on && idle_age >= detach_ms) begin
          drive_on = 1'b0;
        end
      end
      ssl_pkg::ACT_RAMP_SET, ssl_pkg::ACT_JUMP_SET: begin
        goal_deg = limit_angle(req);
        idle_age = '0;
        drive_on = 1'b1;
        if (act == ssl_pkg::ACT_JUMP_SET) begin
          tenths = 11'(goal_deg * TENTHS);
          pulse_reg = pulse_for(goal_deg);
        end
      end
      default: begin
        drive_on = 1'b0;
      end
    endcase
    whole = 8'(tenths / TENTHS);
    st.pulse   = pulse_reg;
    st.enabled = drive_on;
    st.present = whole;
    st.goal    = goal_deg;
    st.moving  = (whole != goal_deg);
  endtask

  always @(posedge clk) begin
    servo_status_t seen;
    servo_status_t want;
    servo_status_t next;
    if (!rst_n) begin
      pace_ms     = 16'd3;
      step_tenths = 11'd20;
      detach_en   = 1'b1;
      detach_ms   = 16'd500;
      lo_lim      = 8'd0;
      hi_lim      = 8'd180;
      tenths      = 11'd900;
      goal_deg    = 8'd90;
      step_age    = '0;
      idle_age    = '0;
      drive_on    = 1'b1;
      pulse_reg   = 12'd1500;
      pending_status.delete();
      mismatches  = 0;
    end else begin
      if (out_valid && !out_stall) begin
        seen = '{out_pulse_compare, out_output_enabled, out_present_angle,
                 out_goal_angle, out_in_motion};
        if (pending_status.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("%0t: unexpected result cmp %0d en %0d now %0d goal %0d moving %0d",
                     $time, seen.pulse, seen.enabled, seen.present, seen.goal, seen.moving);
          end
        end else begin
          want = pending_status.pop_front();
          if (seen.pulse !== want.pulse || seen.enabled !== want.enabled ||
              seen.present !== want.present || seen.goal !== want.goal ||
              seen.moving !== want.moving) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
              $display("%0t: expected cmp %0d en %0d now %0d goal %0d moving %0d",
                       $time, want.pulse, want.enabled, want.present, want.goal,
                       want.moving);
              $display("%0t:   actual cmp %0d en %0d now %0d goal %0d moving %0d",
                       $time, seen.pulse, seen.enabled, seen.present, seen.goal,
                       seen.moving);
            end
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          ssl_pkg::REG_STEP_INTERVAL: pace_ms     = cfg_data;
          ssl_pkg::REG_STEP_SIZE:     step_tenths = cfg_data[10:0];
          ssl_pkg::REG_AUTO_DETACH:   detach_en   = cfg_data[0];
          ssl_pkg::REG_DETACH_DELAY:  detach_ms   = cfg_data;
          ssl_pkg::REG_LOW_LIMIT:     lo_lim      = cfg_data[7:0];
          ssl_pkg::REG_HIGH_LIMIT:    hi_lim      = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        advance_servo(ssl_pkg::action_t'(in_action), in_angle, next);
        pending_status.push_back(next);
      end
    end
    outstanding = pending_status.size();
  end

endmodule

>>> tb/servo_slew_limiter_auto_detach_tb.sv
// Testbench top for the servo slew limiter: clock, reset, stimulus, result-side
// stalls and the verdict. Depends on ssl_pkg, the block and servo_status_check.
`timescale 1ns / 1ps

module servo_slew_limiter_auto_detach_tb;

  // The block has no register at indexes six and seven; writes there are dropped.
  localparam logic [ssl_pkg::CFG_INDEX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [ssl_pkg::CFG_INDEX_W-1:0] REG_SPARE_B = 3'd7;

  localparam int PHASES          = 9;
  localparam int ITEMS_PER_PHASE = 103;
  // The pipeline is three deep, so this drain covers any straggler.
  localparam int DRAIN_CYCLES    = 8;
  // The long receiver hold-off starts once this many transactions went in.
  localparam int HOLD_AT         = 437;
  localparam int HOLD_CYCLES     = 120;
  // Upper bound on the run length for the watchdog.
  localparam int CYCLE_LIMIT     = 400000;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  logic [1:0]                      in_action;
  logic [ssl_pkg::DEG_W-1:0]       in_angle;
  logic                            out_valid;
  logic                            out_stall;
  logic [ssl_pkg::CMP_W-1:0]       out_pulse_compare;
  logic                            out_output_enabled;
  logic [ssl_pkg::DEG_W-1:0]       out_present_angle;
  logic [ssl_pkg::DEG_W-1:0]       out_goal_angle;
  logic                            out_in_motion;
  logic                            cfg_we;
  logic [ssl_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [ssl_pkg::CFG_DATA_W-1:0]  cfg_data;

  int mismatches;
  int outstanding;
  int sent_count = 0;
  int burst_left = 1;
  int cycle_count = 0;

  servo_slew_limiter_auto_detach dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_angle           (in_angle),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_pulse_compare  (out_pulse_compare),
    .out_output_enabled (out_output_enabled),
    .out_present_angle  (out_present_angle),
    .out_goal_angle     (out_goal_angle),
    .out_in_motion      (out_in_motion),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  servo_status_check status_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_angle           (in_angle),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_pulse_compare  (out_pulse_compare),
    .out_output_enabled (out_output_enabled),
    .out_present_angle  (out_present_angle),
    .out_goal_angle     (out_goal_angle),
    .out_in_motion      (out_in_motion),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .mismatches         (mismatches),
    .outstanding        (outstanding)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offers one input transaction and returns at the falling edge after it was
  // taken. The sender works in bursts; when a burst runs out, valid drops for
  // a random gap, except that some bursts run straight into the next one.
  task automatic send(input ssl_pkg::action_t act, input logic [ssl_pkg::DEG_W-1:0] ang);
    int gap;
    in_valid  <= 1'b1;
    in_action <= act;
    in_angle  <= ang;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // Stops offering and waits until every expected result has come back, so
  // that the block is idle before its registers change.
  task automatic settle();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // One register write per cycle. Write enable stays high across a sequence
  // of writes and drops once, after the last one.
  task automatic put_reg(input logic [ssl_pkg::CFG_INDEX_W-1:0] idx,
                         input logic [ssl_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
  endtask

  // Writes every register, then one of the unused indexes with random data,
  // which the block has to ignore.
  task automatic load_settings(input logic [15:0] pace, input logic [15:0] stride,
                               input logic detach_on, input logic [15:0] delay,
                               input logic [7:0] lo, input logic [7:0] hi);
    put_reg(ssl_pkg::REG_STEP_INTERVAL, pace);
    put_reg(ssl_pkg::REG_STEP_SIZE, stride);
    put_reg(ssl_pkg::REG_AUTO_DETACH, {15'd0, detach_on});
    put_reg(ssl_pkg::REG_DETACH_DELAY, delay);
    put_reg(ssl_pkg::REG_LOW_LIMIT, {8'd0, lo});
    put_reg(ssl_pkg::REG_HIGH_LIMIT, {8'd0, hi});
    put_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
            16'($urandom_range(0, 65535)));
    cfg_we <= 1'b0;
  endtask

  // Result side. The receiver stalls in segments of random length, each with
  // its own stall density, from never to almost always. Once, partway through
  // the run, it holds off for a long stretch while the sender keeps offering,
  // so the pipeline fills and pushes back on the input.
  initial begin
    int  seg_left;
    int  chance;
    int  hold_left;
    bit  hold_done;
    out_stall = 1'b0;
    seg_left  = 0;
    chance    = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && sent_count >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(8, 64);
          case ($urandom_range(0, 3))
            0:       chance = 0;
            1:       chance = 25;
            2:       chance = 50;
            default: chance = 85;
          endcase
        end
        seg_left--;
        out_stall <= ($urandom_range(0, 99) < chance);
      end
    end
  end

  // Input side: reset, a directed opening, then randomized phases.
  initial begin
    int                        r;
    int                        md;
    ssl_pkg::action_t          act;
    logic [ssl_pkg::DEG_W-1:0] ang;
    logic [15:0]               pace;
    logic [15:0]               stride;
    logic                      detach_on;
    logic [15:0]               delay;
    logic [7:0]                lo;
    logic [7:0]                hi;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_action = ssl_pkg::ACT_TICK;
    in_angle  = '0;
    cfg_we    = 1'b0;
    cfg_index = ssl_pkg::REG_STEP_INTERVAL;
    cfg_data  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings. A tick at rest neither steps nor detaches yet; jumps hit
    // both ends of the travel, the upper one from an angle above the limit.
    send(ssl_pkg::ACT_TICK, 8'd0);
    send(ssl_pkg::ACT_JUMP_SET, 8'd0);
    send(ssl_pkg::ACT_JUMP_SET, 8'd255);
    send(ssl_pkg::ACT_RAMP_SET, 8'd0);
    // The default interval is three ticks and the opening tick already counts
    // toward it, so the second of these steps.
    repeat (3) send(ssl_pkg::ACT_TICK, 8'd255);
    send(ssl_pkg::ACT_STOP, 8'd170);
    send(ssl_pkg::ACT_TICK, 8'd0);
    send(ssl_pkg::ACT_RAMP_SET, 8'd90);

    // Zero interval and zero step size act as one, a zero detach delay turns
    // the output off on the first idle tick, and the limits cross: requests below
    // the low bound get it and all others get the high bound.
    settle();
    load_settings(16'd0, 16'd0, 1'b1, 16'd0, 8'd100, 8'd50);
    send(ssl_pkg::ACT_RAMP_SET, 8'd20);
    send(ssl_pkg::ACT_RAMP_SET, 8'd200);
    send(ssl_pkg::ACT_JUMP_SET, 8'd75);
    repeat (3) send(ssl_pkg::ACT_TICK, 8'd0);
    send(ssl_pkg::ACT_RAMP_SET, 8'd101);
    repeat (2) send(ssl_pkg::ACT_TICK, 8'd0);

    // Park near the top with auto detach off, then narrow the limits: the
    // stored angle and goal stay where they are and only the compare value
    // is clamped to the new window.
    settle();
    load_settings(16'd1, 16'd1800, 1'b0, 16'd0, 8'd0, 8'd180);
    send(ssl_pkg::ACT_JUMP_SET, 8'd170);
    send(ssl_pkg::ACT_RAMP_SET, 8'd10);
    settle();
    load_settings(16'd1, 16'd5, 1'b1, 16'd65535, 8'd60, 8'd120);
    repeat (3) send(ssl_pkg::ACT_TICK, 8'($urandom_range(0, 255)));

    // Each phase rotates every register but auto detach (off in every third phase)
    // through its low extreme, its high extreme and two random bands, with the
    // rotation offset per register so the combinations differ from phase to phase.
    for (int phase = 0; phase < PHASES; phase++) begin
      md = phase % 4;
      case (md)
        0:       pace = 16'd1;
        1:       pace = 16'd65535;
        2:       pace = 16'($urandom_range(0, 3));
        default: pace = 16'($urandom_range(1, 8));
      endcase
      md = (phase + 1) % 4;
      case (md)
        0:       stride = 16'd1;
        1:       stride = 16'd1800;
        2:       stride = 16'($urandom_range(5, 60));
        default: stride = ($urandom_range(0, 9) == 0) ? 16'd2047
                                                     : 16'($urandom_range(0, 300));
      endcase
      detach_on = (phase % 3 != 2);
      md = (phase + 3) % 4;
      case (md)
        0:       delay = 16'd0;
        1:       delay = 16'd65535;
        2:       delay = 16'($urandom_range(1, 15));
        default: delay = 16'($urandom_range(0, 60));
      endcase
      md = (phase + 2) % 4;
      case (md)
        0:       lo = 8'd0;
        1:       lo = 8'd180;
        2:       lo = 8'($urandom_range(0, 90));
        default: lo = 8'($urandom_range(0, 255));
      endcase
      md = (phase + 1) % 4;
      case (md)
        0:       hi = 8'd180;
        1:       hi = 8'd0;
        2:       hi = 8'($urandom_range(90, 180));
        default: hi = 8'($urandom_range(0, 255));
      endcase
      settle();
      load_settings(pace, stride, detach_on, delay, lo, hi);

      // Mostly ticks, since they drive the ramp and the detach timer, with
      // requests and stops sprinkled in.
      repeat (ITEMS_PER_PHASE) begin
        r = $urandom_range(0, 99);
        act = (r < 70) ? ssl_pkg::ACT_TICK :
              (r < 82) ? ssl_pkg::ACT_RAMP_SET :
              (r < 92) ? ssl_pkg::ACT_JUMP_SET : ssl_pkg::ACT_STOP;
        if ($urandom_range(0, 7) == 0) begin
          ang = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        end else begin
          ang = 8'($urandom_range(0, 255));
        end
        send(act, ang);
      end
    end

    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
